// ----- hdl/dtw_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dtw_pkg: shared definitions for the double-tap wake detector
// Widths, event/phase/status codes, register indexes and the structs that
// run between the control block, the register file and the divider.
// ---------------------------------------------------------------------------
package dtw_pkg;

   localparam int COORD_BITS = 12;
   localparam int TIME_BITS  = 32;
   localparam int MS_BITS    = 16;
   localparam int CSR_BITS   = (COORD_BITS > MS_BITS) ? COORD_BITS : MS_BITS;

   // percent = delta * 100 / range; 100 fits in 7 bits
   localparam int PCT_SCALE  = 100;
   localparam int DIV_BITS   = COORD_BITS + 7;
   localparam int CNT_BITS   = $clog2(DIV_BITS);

   // percentages are clamped to 31 before squaring; any value that large
   // already exceeds both limits
   localparam int PCT_BITS   = 5;
   localparam int PCT_MAX    = (1 << PCT_BITS) - 1;
   localparam int SQ_BITS    = 2 * PCT_BITS + 1;
   localparam int MOVE_LIMIT = 5;
   localparam int PAIR_LIMIT = 15;

   typedef logic [COORD_BITS-1:0] coord_type;
   typedef logic [TIME_BITS-1:0]  time_type;
   typedef logic [MS_BITS-1:0]    ms_type;
   typedef logic [CSR_BITS-1:0]   csr_data_type;
   typedef logic [2:0]            csr_index_type;
   typedef logic [2:0]            req_kind_type;
   typedef logic [2:0]            phase_type;
   typedef logic [3:0]            status_type;
   typedef logic [DIV_BITS-1:0]   dividend_type;
   typedef logic [PCT_BITS-1:0]   pct_type;

   // event kinds
   localparam req_kind_type REQ_POS        = 3'd0;
   localparam req_kind_type REQ_RELEASE    = 3'd1;
   localparam req_kind_type REQ_MULTI      = 3'd2;
   localparam req_kind_type REQ_INVALID    = 3'd3;
   localparam req_kind_type REQ_DISPLAY    = 3'd4;
   localparam req_kind_type REQ_DISCONNECT = 3'd5;

   // gesture phases
   localparam phase_type PH_IDLE    = 3'd0;
   localparam phase_type PH_FIRST   = 3'd1;
   localparam phase_type PH_WAIT    = 3'd2;
   localparam phase_type PH_SECOND  = 3'd3;
   localparam phase_type PH_BLOCKED = 3'd4;

   // status codes
   localparam status_type STS_NONE     = 4'd0;
   localparam status_type STS_FIRST_OK = 4'd1;
   localparam status_type STS_DISABLED = 4'd2;
   localparam status_type STS_DISP_ON  = 4'd3;
   localparam status_type STS_MOVE     = 4'd4;
   localparam status_type STS_DIST     = 4'd5;
   localparam status_type STS_SHORT    = 4'd6;
   localparam status_type STS_TIMEOUT  = 4'd7;
   localparam status_type STS_MULTI    = 4'd8;
   localparam status_type STS_INVALID  = 4'd9;
   localparam status_type STS_LONG     = 4'd10;

   // register indexes
   localparam csr_index_type REG_ENABLE  = 3'd0;
   localparam csr_index_type REG_X_LO    = 3'd1;
   localparam csr_index_type REG_X_HI    = 3'd2;
   localparam csr_index_type REG_Y_LO    = 3'd3;
   localparam csr_index_type REG_Y_HI    = 3'd4;
   localparam csr_index_type REG_MAX_TAP = 3'd5;
   localparam csr_index_type REG_MIN_GAP = 3'd6;
   localparam csr_index_type REG_MAX_GAP = 3'd7;

   typedef struct packed {
      logic      enable;
      coord_type x_lo;
      coord_type x_hi;
      coord_type y_lo;
      coord_type y_hi;
      ms_type    max_tap;
      ms_type    min_gap;
      ms_type    max_gap;
   } cfg_type;

   typedef struct packed {
      logic         start;
      dividend_type dividend;
      coord_type    divisor;
   } div_req_type;

   typedef struct packed {
      logic         done;
      dividend_type quotient;
   } div_rsp_type;

endpackage

// ----- hdl/dtw_div.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dtw_div: shared restoring divider
// One quotient bit per cycle. A zero divisor returns a zero quotient.
// ---------------------------------------------------------------------------
module dtw_div (
   input  logic                 clock,
   input  logic                 reset,
   input  dtw_pkg::div_req_type div_req,
   output dtw_pkg::div_rsp_type div_rsp
);
   import dtw_pkg::*;

   logic                busy_ff;
   logic                done_ff;
   logic [CNT_BITS-1:0] cnt_ff;
   coord_type           rem_ff, rem_in;
   dividend_type        quo_ff, quo_in;
   coord_type           divisor_ff;
   logic [COORD_BITS:0] trial;

   always_comb begin
      trial  = {rem_ff, quo_ff[DIV_BITS-1]};
      rem_in = rem_ff;
      quo_in = {quo_ff[DIV_BITS-2:0], 1'b0};
      if (trial >= {1'b0, divisor_ff}) begin
         rem_in = COORD_BITS'(trial - {1'b0, divisor_ff});
         quo_in = {quo_ff[DIV_BITS-2:0], 1'b1};
      end else begin
         rem_in = trial[COORD_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (div_req.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CNT_BITS'(DIV_BITS - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (div_req.start) begin
         rem_ff     <= '0;
         quo_ff     <= div_req.dividend;
         divisor_ff <= div_req.divisor;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = (divisor_ff == '0) ? '0 : quo_ff;

endmodule

// ----- hdl/dtw_csr.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dtw_csr: configuration registers
// Write-only register file; flags a write that flips the enable bit.
// ---------------------------------------------------------------------------
module dtw_csr (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  dtw_pkg::csr_index_type csr_index,
   input  dtw_pkg::csr_data_type  csr_wdata,
   output dtw_pkg::cfg_type       cfg,
   output logic                   enable_flip
);
   import dtw_pkg::*;

   cfg_type cfg_ff;

   assign enable_flip = csr_we && (csr_index == REG_ENABLE) && (csr_wdata[0] != cfg_ff.enable);
   assign cfg         = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.enable  <= 1'b1;
         cfg_ff.x_lo    <= '0;
         cfg_ff.x_hi    <= COORD_BITS'(4095);
         cfg_ff.y_lo    <= '0;
         cfg_ff.y_hi    <= COORD_BITS'(4095);
         cfg_ff.max_tap <= MS_BITS'(250);
         cfg_ff.min_gap <= MS_BITS'(50);
         cfg_ff.max_gap <= MS_BITS'(500);
      end else if (csr_we) begin
         unique case (csr_index)
            REG_ENABLE:  cfg_ff.enable  <= csr_wdata[0];
            REG_X_LO:    cfg_ff.x_lo    <= csr_wdata[COORD_BITS-1:0];
            REG_X_HI:    cfg_ff.x_hi    <= csr_wdata[COORD_BITS-1:0];
            REG_Y_LO:    cfg_ff.y_lo    <= csr_wdata[COORD_BITS-1:0];
            REG_Y_HI:    cfg_ff.y_hi    <= csr_wdata[COORD_BITS-1:0];
            REG_MAX_TAP: cfg_ff.max_tap <= csr_wdata[MS_BITS-1:0];
            REG_MIN_GAP: cfg_ff.min_gap <= csr_wdata[MS_BITS-1:0];
            REG_MAX_GAP: cfg_ff.max_gap <= csr_wdata[MS_BITS-1:0];
            default: ;
         endcase
      end
   end

endmodule

// ----- hdl/double_tap_wake_gesture_detector.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// double_tap_wake_gesture_detector: double-tap wake recognizer
// Gesture state machine with a sequencer around one shared divider.
// ---------------------------------------------------------------------------
// Every touch event gives exactly one result item (wake, phase, status).
// Events that need no distance check go from SQ_EVAL straight to SQ_OUT,
// which registers the result once the output register is free. A distance
// check (movement or pair distance) costs two percentage divisions, one per
// axis, on the shared one-bit-per-cycle divider; a position or release
// during the second tap may need both checks. The next event can be
// accepted as soon as the result is registered. Only one event is in work
// at a time; the divisions limit the rate unless a stalled result holds SQ_OUT.
// req_ready is high whenever no event is in work, also while a finished
// result waits in the output register.
// ---------------------------------------------------------------------------
module double_tap_wake_gesture_detector (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  dtw_pkg::req_kind_type  req_type,
   input  dtw_pkg::coord_type     req_pos_x,
   input  dtw_pkg::coord_type     req_pos_y,
   input  dtw_pkg::time_type      req_now_ms,
   input  logic                   req_display_asleep,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic                   rsp_wake,
   output dtw_pkg::phase_type     rsp_fsm_state,
   output dtw_pkg::status_type    rsp_status,
   input  logic                   csr_we,
   input  dtw_pkg::csr_index_type csr_index,
   input  dtw_pkg::csr_data_type  csr_wdata
);
   import dtw_pkg::*;

   localparam logic [2:0] SQ_IDLE = 3'd0;
   localparam logic [2:0] SQ_EVAL = 3'd1;
   localparam logic [2:0] SQ_AXIS = 3'd2;
   localparam logic [2:0] SQ_DIV  = 3'd3;
   localparam logic [2:0] SQ_CMP  = 3'd4;
   localparam logic [2:0] SQ_OUT  = 3'd5;

   localparam logic CHK_MOVE = 1'b0;
   localparam logic CHK_PAIR = 1'b1;

   cfg_type     cfg;
   logic        enable_flip;
   div_req_type div_req;
   div_rsp_type div_rsp;

   logic [2:0]   sq_ff, sq_in;
   phase_type    phase_ff, phase_in;
   logic         screen_ff, screen_in;
   coord_type    press_x_ff, press_x_in, press_y_ff, press_y_in;
   coord_type    latest_x_ff, latest_x_in, latest_y_ff, latest_y_in;
   coord_type    first_x_ff, first_x_in, first_y_ff, first_y_in;
   time_type     press_time_ff, press_time_in, first_rel_ff, first_rel_in;

   req_kind_type in_kind_ff;
   coord_type    in_x_ff, in_y_ff;
   time_type     in_now_ff;
   logic         in_asleep_ff;

   coord_type    pt_x_ff, pt_x_in, pt_y_ff, pt_y_in;
   logic         chk_ff, chk_in;
   logic         axis_ff, axis_in;
   pct_type      px_ff, px_in, py_ff, py_in;
   logic         res_wake_ff, res_wake_in;
   status_type   res_status_ff, res_status_in;

   logic         rsp_valid_ff, rsp_valid_in;
   logic         rsp_wake_ff;
   phase_type    rsp_state_ff;
   status_type   rsp_status_ff;

   time_type     tap_len, gap;
   logic         too_long;
   coord_type    a_pt, b_pt, lo, hi, delta, range;
   pct_type      pct_sat;
   logic [SQ_BITS-1:0] sq_sum, lim_sq;
   logic         far;

   dtw_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .cfg         (cfg),
      .enable_flip (enable_flip)
   );

   dtw_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   function automatic status_type block_code(phase_type ph, status_type why);
      return (ph == PH_BLOCKED) ? STS_NONE : why;
   endfunction

   // timing checks on the latched event
   assign tap_len  = in_now_ff - press_time_ff - TIME_BITS'(cfg.max_tap);
   assign too_long = (tap_len != '0) && !tap_len[TIME_BITS-1];
   assign gap      = in_now_ff - first_rel_ff;

   // operands of the current axis division
   always_comb begin
      a_pt = axis_ff ? pt_y_ff : pt_x_ff;
      if (chk_ff == CHK_MOVE) begin
         b_pt = axis_ff ? press_y_ff : press_x_ff;
      end else begin
         b_pt = axis_ff ? first_y_ff : first_x_ff;
      end
      lo    = axis_ff ? cfg.y_lo : cfg.x_lo;
      hi    = axis_ff ? cfg.y_hi : cfg.x_hi;
      delta = (a_pt > b_pt) ? a_pt - b_pt : b_pt - a_pt;
      range = (hi > lo) ? hi - lo : lo - hi;
   end

   assign div_req.start    = (sq_ff == SQ_AXIS);
   assign div_req.dividend = DIV_BITS'(delta) * DIV_BITS'(PCT_SCALE);
   assign div_req.divisor  = range;

   assign pct_sat = (div_rsp.quotient > DIV_BITS'(PCT_MAX)) ? pct_type'(PCT_MAX)
                                                            : div_rsp.quotient[PCT_BITS-1:0];

   assign sq_sum = SQ_BITS'(px_ff) * SQ_BITS'(px_ff) + SQ_BITS'(py_ff) * SQ_BITS'(py_ff);
   assign lim_sq = (chk_ff == CHK_MOVE) ? SQ_BITS'(MOVE_LIMIT * MOVE_LIMIT)
                                        : SQ_BITS'(PAIR_LIMIT * PAIR_LIMIT);
   assign far    = sq_sum > lim_sq;

   always_comb begin
      sq_in         = sq_ff;
      phase_in      = phase_ff;
      screen_in     = screen_ff;
      press_x_in    = press_x_ff;
      press_y_in    = press_y_ff;
      latest_x_in   = latest_x_ff;
      latest_y_in   = latest_y_ff;
      first_x_in    = first_x_ff;
      first_y_in    = first_y_ff;
      press_time_in = press_time_ff;
      first_rel_in  = first_rel_ff;
      pt_x_in       = pt_x_ff;
      pt_y_in       = pt_y_ff;
      chk_in        = chk_ff;
      axis_in       = axis_ff;
      px_in         = px_ff;
      py_in         = py_ff;
      res_wake_in   = res_wake_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;

      unique case (sq_ff)
         SQ_IDLE: begin
            if (req_valid) begin
               sq_in = SQ_EVAL;
            end
         end

         SQ_EVAL: begin
            res_wake_in   = 1'b0;
            res_status_in = STS_NONE;
            axis_in       = 1'b0;
            sq_in         = SQ_OUT;
            case (in_kind_ff)
               REQ_POS: begin
                  if (!cfg.enable) begin
                     res_status_in = block_code(phase_ff, STS_DISABLED);
                     phase_in      = PH_BLOCKED;
                  end else if (!screen_ff) begin
                     res_status_in = block_code(phase_ff, STS_DISP_ON);
                     phase_in      = PH_BLOCKED;
                  end else if (phase_ff == PH_IDLE) begin
                     press_x_in    = in_x_ff;
                     press_y_in    = in_y_ff;
                     latest_x_in   = in_x_ff;
                     latest_y_in   = in_y_ff;
                     press_time_in = in_now_ff;
                     phase_in      = PH_FIRST;
                  end else if (phase_ff == PH_FIRST || phase_ff == PH_SECOND) begin
                     latest_x_in = in_x_ff;
                     latest_y_in = in_y_ff;
                     pt_x_in     = in_x_ff;
                     pt_y_in     = in_y_ff;
                     chk_in      = CHK_MOVE;
                     sq_in       = SQ_AXIS;
                  end else if (phase_ff == PH_WAIT) begin
                     if (gap < TIME_BITS'(cfg.min_gap)) begin
                        res_status_in = STS_SHORT;
                        phase_in      = PH_BLOCKED;
                     end else if (gap > TIME_BITS'(cfg.max_gap)) begin
                        res_status_in = STS_TIMEOUT;
                        phase_in      = PH_BLOCKED;
                     end else begin
                        pt_x_in = in_x_ff;
                        pt_y_in = in_y_ff;
                        chk_in  = CHK_PAIR;
                        sq_in   = SQ_AXIS;
                     end
                  end
               end
               REQ_RELEASE: begin
                  if (phase_ff == PH_FIRST) begin
                     if (too_long) begin
                        res_status_in = STS_LONG;
                        phase_in      = PH_IDLE;
                     end else begin
                        first_x_in    = latest_x_ff;
                        first_y_in    = latest_y_ff;
                        first_rel_in  = in_now_ff;
                        phase_in      = PH_WAIT;
                        res_status_in = STS_FIRST_OK;
                     end
                  end else if (phase_ff == PH_SECOND) begin
                     if (too_long) begin
                        res_status_in = STS_LONG;
                        phase_in      = PH_IDLE;
                     end else begin
                        pt_x_in = latest_x_ff;
                        pt_y_in = latest_y_ff;
                        chk_in  = CHK_MOVE;
                        sq_in   = SQ_AXIS;
                     end
                  end else if (phase_ff == PH_BLOCKED) begin
                     phase_in = PH_IDLE;
                  end
               end
               REQ_MULTI: begin
                  res_status_in = block_code(phase_ff, STS_MULTI);
                  phase_in      = PH_BLOCKED;
               end
               REQ_INVALID: begin
                  res_status_in = block_code(phase_ff, STS_INVALID);
                  phase_in      = PH_BLOCKED;
               end
               REQ_DISPLAY: begin
                  screen_in     = in_asleep_ff;
                  phase_in      = PH_IDLE;
                  res_status_in = in_asleep_ff ? STS_NONE : STS_DISP_ON;
               end
               REQ_DISCONNECT: begin
                  phase_in = PH_IDLE;
               end
               default: ;
            endcase
         end

         SQ_AXIS: begin
            sq_in = SQ_DIV;
         end

         SQ_DIV: begin
            if (div_rsp.done) begin
               if (!axis_ff) begin
                  px_in   = pct_sat;
                  axis_in = 1'b1;
                  sq_in   = SQ_AXIS;
               end else begin
                  py_in = pct_sat;
                  sq_in = SQ_CMP;
               end
            end
         end

         SQ_CMP: begin
            sq_in   = SQ_OUT;
            axis_in = 1'b0;
            if (in_kind_ff == REQ_POS) begin
               if (phase_ff == PH_WAIT) begin
                  if (far) begin
                     res_status_in = STS_DIST;
                     phase_in      = PH_BLOCKED;
                  end else begin
                     press_x_in    = in_x_ff;
                     press_y_in    = in_y_ff;
                     latest_x_in   = in_x_ff;
                     latest_y_in   = in_y_ff;
                     press_time_in = in_now_ff;
                     phase_in      = PH_SECOND;
                  end
               end else if (far) begin
                  res_status_in = (chk_ff == CHK_MOVE) ? STS_MOVE : STS_DIST;
                  phase_in      = PH_BLOCKED;
               end else if (chk_ff == CHK_MOVE && phase_ff == PH_SECOND) begin
                  chk_in = CHK_PAIR;
                  sq_in  = SQ_AXIS;
               end
            end else begin
               // release that ends the second tap
               if (far) begin
                  res_status_in = (chk_ff == CHK_MOVE) ? STS_MOVE : STS_DIST;
                  phase_in      = PH_IDLE;
               end else if (chk_ff == CHK_MOVE) begin
                  chk_in = CHK_PAIR;
                  sq_in  = SQ_AXIS;
               end else begin
                  res_wake_in = 1'b1;
                  phase_in    = PH_IDLE;
               end
            end
         end

         SQ_OUT: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               sq_in        = SQ_IDLE;
            end
         end

         default: begin
            sq_in = SQ_IDLE;
         end
      endcase

      if (enable_flip) begin
         phase_in = PH_IDLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_ff         <= SQ_IDLE;
         phase_ff      <= PH_IDLE;
         screen_ff     <= 1'b0;
         press_x_ff    <= '0;
         press_y_ff    <= '0;
         latest_x_ff   <= '0;
         latest_y_ff   <= '0;
         first_x_ff    <= '0;
         first_y_ff    <= '0;
         press_time_ff <= '0;
         first_rel_ff  <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         sq_ff         <= sq_in;
         phase_ff      <= phase_in;
         screen_ff     <= screen_in;
         press_x_ff    <= press_x_in;
         press_y_ff    <= press_y_in;
         latest_x_ff   <= latest_x_in;
         latest_y_ff   <= latest_y_in;
         first_x_ff    <= first_x_in;
         first_y_ff    <= first_y_in;
         press_time_ff <= press_time_in;
         first_rel_ff  <= first_rel_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      pt_x_ff       <= pt_x_in;
      pt_y_ff       <= pt_y_in;
      chk_ff        <= chk_in;
      axis_ff       <= axis_in;
      px_ff         <= px_in;
      py_ff         <= py_in;
      res_wake_ff   <= res_wake_in;
      res_status_ff <= res_status_in;
      if (req_valid && req_ready) begin
         in_kind_ff   <= req_type;
         in_x_ff      <= req_pos_x;
         in_y_ff      <= req_pos_y;
         in_now_ff    <= req_now_ms;
         in_asleep_ff <= req_display_asleep;
      end
      if (sq_ff == SQ_OUT && (!rsp_valid_ff || rsp_ready)) begin
         rsp_wake_ff   <= res_wake_ff;
         rsp_state_ff  <= phase_ff;
         rsp_status_ff <= res_status_ff;
      end
   end

   assign req_ready     = (sq_ff == SQ_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_wake      = rsp_wake_ff;
   assign rsp_fsm_state = rsp_state_ff;
   assign rsp_status    = rsp_status_ff;

endmodule

// ----- hdl/dtw_checker.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dtw_checker: port-level checks for the double-tap wake detector
// Watches the handshakes and result fields; bound to the top level.
// ---------------------------------------------------------------------------
module dtw_checker (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_ready,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic                rsp_wake,
   input dtw_pkg::phase_type  rsp_fsm_state,
   input dtw_pkg::status_type rsp_status
);
   import dtw_pkg::*;

   // a stalled result holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_wake)
         && $stable(rsp_fsm_state) && $stable(rsp_status))
      else $error("result item changed while stalled");

   // one event in work at a time
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input accepted while an item is in work");

   // a wake ends the gesture cleanly
   a_wake: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_wake |-> rsp_status == STS_NONE && rsp_fsm_state == PH_IDLE)
      else $error("wake with nonzero status or phase not idle");

   // first tap accepted leaves the detector waiting for the second
   a_first: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STS_FIRST_OK |-> rsp_fsm_state == PH_WAIT && !rsp_wake)
      else $error("first tap ok without wait phase");

   // blocking codes leave the detector blocked
   a_block: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STS_DISABLED || rsp_status == STS_MULTI
         || rsp_status == STS_INVALID || rsp_status == STS_SHORT
         || rsp_status == STS_TIMEOUT) |-> rsp_fsm_state == PH_BLOCKED)
      else $error("blocking status without blocked phase");

endmodule

bind double_tap_wake_gesture_detector dtw_checker u_checker (.*);
